>>> rtl/bitmap_block_allocator_top_defines.svh
// Assertion macros shared by the allocator RTL.
// No dependencies.
`ifndef BITMAP_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define BBA_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequence is checked in the next cycle.
`define BBA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> rtl/bba_pkg.sv
// Types and codes for the bitmap block allocator.
// No dependencies.
`default_nettype none
package bba_pkg;
    localparam int BLOCKS_PER_MAP = 4096;
    localparam int MAX_MAPS = 4;
    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;
    localparam logic [1:0] ACT_RSVD  = 2'd3;
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;
    localparam logic REG_BLOCK_SIZE_LOG2 = 1'b0;
    localparam logic REG_RESERVED_BLOCKS = 1'b1;

    typedef struct packed {
        logic [1:0]  action;
        logic [23:0] byte_count;
        logic [17:0] handle;
    } bba_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [17:0] result_handle;
        logic        is_allocated;
    } bba_out_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_SCAN_RD, S_SCAN, S_WR_RD, S_WR, S_QUERY, S_DONE
    } bba_state_t;
endpackage
`default_nettype wire

>>> rtl/bitmap_block_allocator_top.sv
// Bitmap block allocator: next-fit search over a word-wide bitmap memory.
// A free or a bad request is answered from the decode state, a query after one bitmap read;
// an allocate scans one bit a cycle, passing a fetch state before each word and at each
// map change, and reports its result once its run is found, before its bits are written.
// One item at a time: the next transfer is taken only back in the idle state, after the
// result transfer and after every word of the run is written. Reset: a clearing pass over
// MAX_MAPS*BLOCKS_PER_MAP/64 words runs before the first transfer; registers reset to 12, 1.
`default_nettype none
module bitmap_block_allocator_top
    import bba_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     cfg_we,
    input  wire logic     cfg_index,
    input  wire logic [3:0] cfg_wdata,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire bba_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output bba_out_t      m_data
);
    localparam int WORDS = MAX_MAPS * BLOCKS_PER_MAP / 64;
    localparam int AW = $clog2(WORDS);
    localparam int PW = $clog2(BLOCKS_PER_MAP) + 1;
    localparam int MW = $clog2(MAX_MAPS) + 1;
    localparam int MIW = (MAX_MAPS > 1) ? $clog2(MAX_MAPS) : 1;
    localparam int WPM = BLOCKS_PER_MAP / 64;

    // Bitmap memory and pointer memory.
    logic [63:0] mem [WORDS];
    logic [63:0] rdata_reg;
    logic [PW-1:0] ptr_mem [MAX_MAPS];

    bba_state_t state_reg, state_next;
    logic [3:0] log2_reg, resv_reg;
    logic [AW-1:0] clr_reg;
    bba_in_t req_reg;
    logic [MW-1:0] maps_reg, maps_next;
    logic [MIW-1:0] map_reg, map_next;
    logic [PW-1:0] p_reg, p_next;       // scan position
    logic [PW-1:0] k_reg, k_next;       // free run length
    logic [PW-1:0] n_reg;
    logic [PW-1:0] at_reg, at_next;     // run start / write cursor
    logic [PW-1:0] end_reg, end_next;   // write end (exclusive)
    logic fill_reg, fill_next;          // set or clear bits
    logic rd_en;
    logic [AW-1:0] rd_addr;
    logic wr_en;
    logic [63:0] wr_data;
    logic ptr_we;
    logic [PW-1:0] ptr_wd;
    logic [MIW-1:0] ptr_wa;
    logic out_v_reg;
    bba_out_t out_reg, out_next;
    logic out_load;
    logic [3:0] l2, rv;
    logic [PW-1:0] resv_p;
    logic [24:0] nfull;
    logic cur_bit;
    bba_state_t dp_state;
    logic [MIW-1:0] pw_map;
    logic [PW-1:0] start_v;
    logic [63:0] mask;
    logic [PW-1:0] seg_end;
    logic [PW-1:0] word_end_at;

    assign l2 = (log2_reg < 4'd9) ? 4'd9 : ((log2_reg > 4'd12) ? 4'd12 : log2_reg);
    assign rv = (resv_reg < 4'd1) ? 4'd1 : ((resv_reg > 4'd8) ? 4'd8 : resv_reg);
    assign resv_p = PW'(rv);
    assign nfull = (25'(req_reg.byte_count) + (25'd1 << l2) - 25'd1) >> l2;

    function automatic logic [AW-1:0] waddr(input logic [MIW-1:0] m, input logic [PW-1:0] p);
        logic [31:0] a;
        a = 32'(m) * 32'(WPM) + 32'(p >> 6);
        return a[AW-1:0];
    endfunction

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log2_reg <= 4'd12;
            resv_reg <= 4'd1;
        end else if (cfg_we) begin
            if (cfg_index == REG_BLOCK_SIZE_LOG2) log2_reg <= cfg_wdata;
            else resv_reg <= cfg_wdata;
        end
    end

    // Memories: registered bitmap read, single write port each.
    always_ff @(posedge aclk) begin
        if (rd_en) rdata_reg <= mem[rd_addr];
        if (wr_en) mem[rd_addr] <= wr_data;
        if (ptr_we) ptr_mem[ptr_wa] <= ptr_wd;
    end

    assign cur_bit = rdata_reg[p_reg[5:0]];
    assign word_end_at = {at_reg[PW-1:6], 6'd0} + PW'(64);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_reg == AW'(WORDS - 1)) state_next = S_IDLE;
            S_IDLE: if (s_valid) state_next = S_DECODE;
            S_DECODE: state_next = S_DONE;
            default: state_next = state_reg;
        endcase
        // Detailed transitions come from the datapath block below.
        if (state_reg != S_CLEAR && state_reg != S_IDLE) state_next = dp_state;
    end

    // Datapath and sequencing.
    always_comb begin
        dp_state = state_reg;
        maps_next = maps_reg;
        map_next = map_reg;
        p_next = p_reg;
        k_next = k_reg;
        at_next = at_reg;
        end_next = end_reg;
        fill_next = fill_reg;
        rd_en = 1'b0;
        rd_addr = waddr(map_reg, p_reg);
        wr_en = 1'b0;
        wr_data = rdata_reg;
        ptr_we = 1'b0;
        ptr_wd = '0;
        ptr_wa = map_reg;
        out_load = 1'b0;
        out_next = '0;
        pw_map = '0;
        start_v = resv_p;
        mask = '0;
        seg_end = end_reg;
        if (state_reg == S_CLEAR) begin
            rd_addr = clr_reg;
            wr_en = 1'b1;
            wr_data = (clr_reg == '0) ? ((64'd1 << rv) - 64'd1) : 64'd0;
            ptr_we = 1'b1;
            ptr_wa = clr_reg[MIW-1:0];
            ptr_wd = resv_p;
        end
        case (state_reg)
            S_DECODE: begin
                pw_map = req_reg.handle[16 +: MIW];
                if (req_reg.action == ACT_ALLOC) begin
                    if (nfull == 25'd0 || nfull > 25'(BLOCKS_PER_MAP) - 25'(rv)) begin
                        out_load = 1'b1; out_next.status = ST_BAD; dp_state = S_DONE;
                    end else begin
                        map_next = '0;
                        p_next = resv_p;
                        if (nfull > 25'd1 && ptr_mem[MIW'(0)] > resv_p) p_next = ptr_mem[MIW'(0)];
                        k_next = '0;
                        dp_state = (maps_reg == '0) ? S_DONE : S_SCAN_RD;
                        if (maps_reg == '0) begin
                            out_load = 1'b1; out_next.status = ST_NOSPACE;
                        end
                    end
                end else if (req_reg.action == ACT_FREE || req_reg.action == ACT_QUERY) begin
                    if (32'(req_reg.handle[17:16]) < 32'(maps_reg)
                        && req_reg.handle[15:0] >= 16'(rv)
                        && 32'(req_reg.handle[15:0]) < BLOCKS_PER_MAP
                        && (req_reg.action == ACT_QUERY
                            || nfull <= 25'(BLOCKS_PER_MAP) - 25'(req_reg.handle[15:0]))) begin
                        map_next = pw_map;
                        p_next = PW'(req_reg.handle[15:0]);
                        at_next = PW'(req_reg.handle[15:0]);
                        end_next = PW'(25'(req_reg.handle[15:0]) + nfull);
                        fill_next = 1'b0;
                        if (req_reg.action == ACT_QUERY) begin
                            rd_en = 1'b1;
                            rd_addr = waddr(pw_map, PW'(req_reg.handle[15:0]));
                            dp_state = S_QUERY;
                        end else begin
                            ptr_we = 1'b1; ptr_wa = pw_map;
                            ptr_wd = PW'(req_reg.handle[15:0]);
                            out_load = 1'b1; out_next.status = ST_OK;
                            dp_state = (nfull == 25'd0) ? S_DONE : S_WR_RD;
                        end
                    end else begin
                        out_load = 1'b1; out_next.status = ST_BAD; dp_state = S_DONE;
                    end
                end else begin
                    out_load = 1'b1; out_next.status = ST_BAD; dp_state = S_DONE;
                end
            end
            S_QUERY: begin
                out_load = 1'b1;
                out_next.status = ST_OK;
                out_next.is_allocated = cur_bit;
                dp_state = S_DONE;
            end
            S_SCAN_RD: begin
                if (p_reg >= PW'(BLOCKS_PER_MAP)) begin
                    // This map has no room; go on to the next one, open a new one, or report no space.
                    if (32'(map_reg) + 1 < 32'(maps_reg)) begin
                        map_next = map_reg + MIW'(1);
                        start_v = resv_p;
                        if (n_reg > PW'(1) && ptr_mem[map_reg + MIW'(1)] > resv_p)
                            start_v = ptr_mem[map_reg + MIW'(1)];
                        p_next = start_v; k_next = '0;
                    end else if (32'(maps_reg) < MAX_MAPS) begin
                        // Open a new map; reserved bits and run both go in by writes.
                        map_next = maps_reg[MIW-1:0];
                        maps_next = maps_reg + MW'(1);
                        at_next = '0;
                        end_next = resv_p + n_reg;
                        fill_next = 1'b1;
                        p_next = '0;
                        ptr_we = 1'b1; ptr_wa = maps_reg[MIW-1:0];
                        ptr_wd = ((resv_p + n_reg) == PW'(BLOCKS_PER_MAP)) ? resv_p
                                 : resv_p + n_reg;
                        out_load = 1'b1; out_next.status = ST_OK;
                        out_next.result_handle = 18'({maps_reg[MIW-1:0], 16'(rv)});
                        dp_state = S_WR_RD;
                    end else begin
                        out_load = 1'b1; out_next.status = ST_NOSPACE;
                        dp_state = S_DONE;
                    end
                end else begin
                    rd_en = 1'b1;
                    dp_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // One bit per cycle; refetch on word crossing.
                if (cur_bit) begin
                    k_next = '0;
                    p_next = p_reg + PW'(1);
                end else begin
                    k_next = k_reg + PW'(1);
                    p_next = p_reg + PW'(1);
                end
                if (!cur_bit && k_reg + PW'(1) == n_reg) begin
                    at_next = p_reg + PW'(1) - n_reg;
                    end_next = p_reg + PW'(1);
                    fill_next = 1'b1;
                    p_next = p_reg + PW'(1) - n_reg;
                    ptr_we = 1'b1;
                    ptr_wd = ((p_reg + PW'(1)) == PW'(BLOCKS_PER_MAP)) ? resv_p
                             : p_reg + PW'(1);
                    out_load = 1'b1; out_next.status = ST_OK;
                    out_next.result_handle =
                        18'({map_reg, 16'(p_reg + PW'(1) - n_reg)});
                    dp_state = S_WR_RD;
                end else if (p_next >= PW'(BLOCKS_PER_MAP) || p_next[5:0] == 6'd0) begin
                    dp_state = S_SCAN_RD;
                end
            end
            S_WR_RD: begin
                if (at_reg >= end_reg) dp_state = S_DONE;
                else begin
                    rd_en = 1'b1;
                    rd_addr = waddr(map_reg, at_reg);
                    dp_state = S_WR;
                end
            end
            S_WR: begin
                // Set or clear the run's bits within one word.
                seg_end = (end_reg < word_end_at) ? end_reg : word_end_at;
                for (int b = 0; b < 64; b++) begin
                    mask[b] = (PW'({at_reg[PW-1:6], 6'(b)}) >= at_reg)
                              && (PW'({at_reg[PW-1:6], 6'(b)}) < seg_end);
                end
                wr_en = 1'b1;
                rd_addr = waddr(map_reg, at_reg);
                wr_data = fill_reg ? (rdata_reg | mask) : (rdata_reg & ~mask);
                at_next = seg_end;
                dp_state = S_WR_RD;
            end
            S_DONE: if (!out_v_reg) dp_state = S_IDLE;
            default: dp_state = state_reg;
        endcase
    end

    // Registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            maps_reg <= MW'(1);
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            maps_reg <= maps_next;
            if (state_reg == S_CLEAR) clr_reg <= clr_reg + AW'(1);
            if (out_load) out_v_reg <= 1'b1;
            else if (m_ready) out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        map_reg <= map_next;
        p_reg <= p_next;
        k_reg <= k_next;
        at_reg <= at_next;
        end_reg <= end_next;
        fill_reg <= fill_next;
        if (out_load) out_reg <= out_next;
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
        if (state_reg == S_DECODE) n_reg <= PW'(nfull);
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_v_reg;
    assign m_data = out_reg;

    `include "bitmap_block_allocator_top_defines.svh"
    `BBA_ASSERT_IMP(a_no_in_busy, aclk, aresetn, state_reg != S_IDLE, !s_ready)
    `BBA_ASSERT_IMP(a_maps_range, aclk, aresetn, 1'b1, maps_reg != '0)
    `BBA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
endmodule
`default_nettype wire

>>> tb/bitmap_block_allocator_top_tb.sv
// Self-checking testbench for the bitmap block allocator: a directed pass, then random
// allocate/free/query/reserved traffic under several register settings and handshake
// patterns. Depends on bba_pkg and bitmap_block_allocator_top.
`default_nettype none
module bitmap_block_allocator_top_tb;
    import bba_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BPM = 4096;
    localparam int MAPS = 4;

    // Mirror of the allocator state; predicts one response per request.
    class alloc_scoreboard;
        bit          bits[MAPS][BPM];
        int unsigned next_fit[MAPS];
        int unsigned maps_active;
        logic [3:0]  size_log2_reg;
        logic [3:0]  resv_reg;
        bba_out_t    expected_q[$];
        logic [17:0] live_handle[$];
        logic [23:0] live_bytes[$];
        int          errors;

        function int unsigned size_log2();
            if (size_log2_reg < 9) return 9;
            if (size_log2_reg > 12) return 12;
            return size_log2_reg;
        endfunction

        function int unsigned resv();
            if (resv_reg < 1) return 1;
            if (resv_reg > 8) return 8;
            return resv_reg;
        endfunction

        function void clear_all();
            size_log2_reg = 12;
            resv_reg = 1;
            foreach (bits[m, p]) bits[m][p] = 0;
            for (int m = 0; m < MAPS; m++) next_fit[m] = resv();
            for (int p = 0; p < resv(); p++) bits[0][p] = 1;
            maps_active = 1;
            errors = 0;
        endfunction

        function void write_reg(logic idx, logic [3:0] val);
            if (idx == REG_BLOCK_SIZE_LOG2) size_log2_reg = val;
            else resv_reg = val;
        endfunction

        // Next-fit run search within one map, no wrap at the map end.
        function bit find_run(int m, int unsigned from, int unsigned n,
                              output int unsigned at);
            int unsigned p;
            int unsigned k;
            p = from;
            at = 0;
            while (p < BPM) begin
                while (p < BPM && bits[m][p]) p++;
                if (p >= BPM) return 0;
                k = 0;
                while (k < n && p + k < BPM && !bits[m][p + k]) k++;
                if (k == n) begin
                    at = p;
                    return 1;
                end
                p += k + 1;
            end
            return 0;
        endfunction

        // Called for every accepted request transfer.
        function void note_request(bba_in_t req);
            bba_out_t    rsp;
            int unsigned n, r, m, pos, at, start, np;
            bit          found;
            r = resv();
            n = (int'(req.byte_count) + (1 << size_log2()) - 1) >> size_log2();
            rsp = '0;
            rsp.status = ST_BAD;
            if (req.action == ACT_ALLOC) begin
                if (n != 0 && n <= BPM - r) begin
                    found = 0;
                    at = 0;
                    for (m = 0; m < maps_active; m++) begin
                        start = r;
                        if (n > 1 && next_fit[m] > r) start = next_fit[m];
                        if (find_run(m, start, n, at)) begin
                            found = 1;
                            break;
                        end
                    end
                    if (!found && maps_active < MAPS) begin
                        m = maps_active;
                        maps_active++;
                        for (int j = 0; j < r; j++) bits[m][j] = 1;
                        at = r;
                        found = 1;
                    end
                    if (found) begin
                        np = (at + n) % BPM;
                        next_fit[m] = (np == 0) ? r : np;
                        for (int j = 0; j < n; j++) bits[m][at + j] = 1;
                        rsp.status = ST_OK;
                        rsp.result_handle = {m[1:0], at[15:0]};
                        live_handle.push_back(rsp.result_handle);
                        live_bytes.push_back(req.byte_count);
                    end else begin
                        rsp.status = ST_NOSPACE;
                    end
                end
            end else if (req.action == ACT_FREE || req.action == ACT_QUERY) begin
                m = req.handle[17:16];
                pos = req.handle[15:0];
                if (m < maps_active && pos >= r && pos < BPM) begin
                    if (req.action == ACT_QUERY) begin
                        rsp.is_allocated = bits[m][pos];
                        rsp.status = ST_OK;
                    end else if (n <= BPM - pos) begin
                        for (int j = 0; j < n; j++) bits[m][pos + j] = 0;
                        next_fit[m] = pos;
                        rsp.status = ST_OK;
                    end
                end
            end
            expected_q.push_back(rsp);
        endfunction

        // Called for every accepted response transfer.
        function void check_result(bba_out_t got);
            bba_out_t exp;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected response %p", $time, got);
                return;
            end
            exp = expected_q.pop_front();
            if (got.status !== exp.status) begin
                errors++;
                $display("%0t: status expected %0d got %0d", $time, exp.status, got.status);
            end
            if (got.result_handle !== exp.result_handle) begin
                errors++;
                $display("%0t: result_handle expected 0x%05h got 0x%05h", $time,
                         exp.result_handle, got.result_handle);
            end
            if (got.is_allocated !== exp.is_allocated) begin
                errors++;
                $display("%0t: is_allocated expected %0b got %0b", $time,
                         exp.is_allocated, got.is_allocated);
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic        cfg_index = REG_BLOCK_SIZE_LOG2;
    logic [3:0]  cfg_wdata = '0;
    logic        s_valid = 0;
    logic        s_ready;
    bba_in_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 0;
    bba_out_t    m_data;

    alloc_scoreboard sb = new();
    int          req_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles = 0;

    bitmap_block_allocator_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #1 aclk = ~aclk;

    // Watchdog.
    initial begin
        #200_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Sample both channels at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sb.note_request(s_data);
            req_count++;
        end
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // Response side: long hold-off when requested, otherwise random stalls.
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready = 0;
            hold_cycles--;
        end else begin
            m_ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Offer one request; valid stays high afterwards unless the next one idles.
    task automatic send_request(logic [1:0] act, logic [23:0] bytes, logic [17:0] hnd);
        int seen;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid = 0;
            @(negedge aclk);
        end
        s_data = '{action: act, byte_count: bytes, handle: hnd};
        s_valid = 1;
        seen = req_count;
        do @(negedge aclk); while (req_count == seen);
    endtask

    // Wait until every result has come and the block is back at its input.
    task automatic wait_drained();
        s_valid = 0;
        while (sb.expected_q.size() != 0) @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        repeat (64) @(negedge aclk);
    endtask

    task automatic set_regs(logic [3:0] size_log2, logic [3:0] resv);
        wait_drained();
        cfg_we = 1;
        cfg_index = REG_BLOCK_SIZE_LOG2;
        cfg_wdata = size_log2;
        sb.write_reg(REG_BLOCK_SIZE_LOG2, size_log2);
        @(negedge aclk);
        cfg_index = REG_RESERVED_BLOCKS;
        cfg_wdata = resv;
        sb.write_reg(REG_RESERVED_BLOCKS, resv);
        @(negedge aclk);
        cfg_we = 0;
    endtask

    // Random traffic: mostly small allocations paired with frees of live runs.
    task automatic random_traffic(int count);
        int          r, k, bs;
        logic [23:0] bytes;
        logic [17:0] hnd;
        for (int i = 0; i < count; i++) begin
            bs = 1 << sb.size_log2();
            r = $urandom_range(0, 99);
            if (sb.live_handle.size() > 40) r = 50;
            if (r < 40) begin
                k = $urandom_range(0, 99);
                if (k < 85) bytes = 24'($urandom_range(1, 8 * bs));
                else if (k < 93) bytes = 24'($urandom_range(0, 1));
                else bytes = 24'($urandom);
                send_request(ACT_ALLOC, bytes, 18'($urandom));
            end else if (r < 75) begin
                if (sb.live_handle.size() > 0 && $urandom_range(0, 9) != 0) begin
                    k = $urandom_range(0, sb.live_handle.size() - 1);
                    hnd = sb.live_handle[k];
                    bytes = sb.live_bytes[k];
                    sb.live_handle.delete(k);
                    sb.live_bytes.delete(k);
                end else begin
                    hnd = 18'($urandom);
                    bytes = 24'($urandom_range(0, 4 * bs));
                end
                send_request(ACT_FREE, bytes, hnd);
            end else if (r < 95) begin
                if (sb.live_handle.size() > 0 && $urandom_range(0, 3) != 0)
                    hnd = 18'(sb.live_handle[$urandom_range(0, sb.live_handle.size() - 1)]
                          + $urandom_range(0, 3));
                else if ($urandom_range(0, 1) != 0)
                    hnd = {2'($urandom_range(0, 3)), 16'($urandom_range(0, BPM + 2))};
                else
                    hnd = 18'($urandom);
                send_request(ACT_QUERY, 24'($urandom), hnd);
            end else begin
                send_request(ACT_RSVD, 24'($urandom), 18'($urandom));
            end
        end
    endtask

    initial begin
        sb.clear_all();
        repeat (8) @(negedge aclk);
        aresetn = 1;

        // Directed: edge sizes, map activation, exhaustion and the bad cases.
        send_request(ACT_QUERY, 24'd0, {2'd2, 16'd5});
        send_request(ACT_ALLOC, 24'd0, 18'd0);
        send_request(ACT_ALLOC, 24'd1, 18'd0);
        send_request(ACT_ALLOC, 24'hFFFFFF, 18'd0);
        for (int m = 0; m < 5; m++) send_request(ACT_ALLOC, 24'(4095 * 4096), 18'd0);
        send_request(ACT_QUERY, 24'd0, {2'd3, 16'd4095});
        send_request(ACT_QUERY, 24'd0, {2'd1, 16'd0});
        send_request(ACT_QUERY, 24'd0, {2'd1, 16'd4096});
        send_request(ACT_QUERY, 24'd0, 18'h3FFFF);
        send_request(ACT_FREE, 24'd8192, {2'd1, 16'd4095});
        send_request(ACT_FREE, 24'd0, {2'd2, 16'd100});
        send_request(ACT_FREE, 24'd4096, {2'd0, 16'd1});
        for (int m = 1; m < 4; m++)
            send_request(ACT_FREE, 24'(4095 * 4096), {m[1:0], 16'd1});
        send_request(ACT_QUERY, 24'd0, {2'd2, 16'd1});
        send_request(ACT_RSVD, 24'hFFFFFF, 18'h3FFFF);
        send_request(ACT_ALLOC, 24'(3 * 4096), 18'd0);
        send_request(ACT_ALLOC, 24'd4096, 18'd0);

        // Smallest blocks, most reserved blocks, no idling.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_regs(4'd9, 4'd8);
        random_traffic(250);

        // Out-of-range register values, sender mostly idle.
        set_regs(4'd0, 4'd15);
        send_idle_pct = 68;
        random_traffic(200);

        // Receiver stalls, including one long hold-off while requests keep coming.
        set_regs(4'd15, 4'd0);
        send_idle_pct = 0;
        recv_stall_pct = 68;
        hold_cycles = 2000;
        random_traffic(200);

        // Both sides idle now and then.
        set_regs(4'd10, 4'd3);
        send_idle_pct = 13;
        recv_stall_pct = 13;
        random_traffic(200);

        // Back to reset values; sender pauses until everything has come back.
        set_regs(4'd12, 4'd1);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_traffic(150);
        wait_drained();
        send_idle_pct = 13;
        recv_stall_pct = 68;
        random_traffic(150);

        wait_drained();
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
+incdir+rtl
rtl/bba_pkg.sv
rtl/bitmap_block_allocator_top.sv
tb/bitmap_block_allocator_top_tb.sv
